// ----- rtl/core/gtg_pkg.sv -----
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types and constants of the go-to-goal PI controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

	localparam int DW = 33;   // magnitude of a position difference
	localparam int XW = 36;   // CORDIC x/y datapath
	localparam int ZW = 30;   // CORDIC angle accumulator, Q.24
	localparam int BW = 19;   // bearing, Q3.13
	localparam int EW = 20;   // heading error, Q3.13
	localparam int MAW = 33;  // multiplier operand a
	localparam int MBW = 17;  // multiplier operand b
	localparam int MPW = MAW + MBW;

	localparam logic signed [ZW-1:0] PI_Q24 = ZW'(52707179);
	localparam logic signed [EW-1:0] PI_Q13 = EW'(25736);
	localparam logic signed [EW-1:0] TWO_PI_Q13 = EW'(51472);
	localparam logic [31:0] TEN_M_Q16 = 32'd655360;
	localparam logic [31:0] INTEGRAL_MAX = 32'hFFFF_FFFF;

	localparam logic [2:0] REG_MAX_VEL = 3'd0;
	localparam logic [2:0] REG_MAX_TURN = 3'd1;
	localparam logic [2:0] REG_KP_DIST = 3'd2;
	localparam logic [2:0] REG_KP_HEAD = 3'd3;
	localparam logic [2:0] REG_KI_DIST = 3'd4;
	localparam logic [2:0] REG_ARR_RAD = 3'd5;
	localparam logic [2:0] REG_TURN_ANG = 3'd6;
	localparam logic [2:0] REG_DEADBAND = 3'd7;

	typedef struct packed {
		logic start;
		logic busy;
	} unit_ctl_t;

	// atan(2^-i), Q.24 radians
	function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		unique case (i)
			5'd0: r = ZW'(13176795);
			5'd1: r = ZW'(7778716);
			5'd2: r = ZW'(4110060);
			5'd3: r = ZW'(2086331);
			5'd4: r = ZW'(1047214);
			5'd5: r = ZW'(524117);
			5'd6: r = ZW'(262123);
			5'd7: r = ZW'(131069);
			5'd8: r = ZW'(65536);
			5'd9: r = ZW'(32768);
			5'd10: r = ZW'(16384);
			5'd11: r = ZW'(8192);
			5'd12: r = ZW'(4096);
			5'd13: r = ZW'(2048);
			5'd14: r = ZW'(1024);
			5'd15: r = ZW'(512);
			5'd16: r = ZW'(256);
			5'd17: r = ZW'(128);
			5'd18: r = ZW'(64);
			5'd19: r = ZW'(32);
			5'd20: r = ZW'(16);
			5'd21: r = ZW'(8);
			5'd22: r = ZW'(4);
			5'd23: r = ZW'(2);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/gtg_mul.sv -----
// ----------------------------------------------------------------------------
// gtg_mul
// Shared unsigned 33x17 multiplier with registered product.
// ----------------------------------------------------------------------------
module gtg_mul import gtg_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [MAW-1:0] a,
	input  logic [MBW-1:0] b,
	output logic [MPW-1:0] p
);

	logic [MPW-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= MPW'(a) * MPW'(b);
		end
	end

	assign p = p_q;

endmodule

// ----- rtl/core/gtg_isqrt.sv -----
// ----------------------------------------------------------------------------
// gtg_isqrt
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module gtg_isqrt import gtg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic [31:0] root
);

	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [34:0] r2;
	logic [34:0] trial;

	assign r2 = {rem_q[32:0], rad_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (r2 >= trial) begin
				rem_q <= 34'(r2 - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q <= r2[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// ----- rtl/core/gtg_cordic.sv -----
// ----------------------------------------------------------------------------
// gtg_cordic
// Vectoring CORDIC, one micro-rotation per cycle; bearing in Q3.13.
// ----------------------------------------------------------------------------
module gtg_cordic import gtg_pkg::*; #(
	parameter int STAGES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] dx,
	input  logic signed [DW-1:0] dy,
	output logic                 busy,
	output logic signed [BW-1:0] bearing
);

	localparam int CW = $clog2(STAGES);

	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [CW-1:0]        i_q;
	logic                 busy_q;
	logic signed [XW-1:0] xs, ys;
	logic signed [ZW-1:0] zr;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q <= '0;
		end else if (busy_q) begin
			i_q <= i_q + CW'(1);
			if (i_q == CW'(STAGES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// left half plane: fold over and preload +-pi
			if (dx < 0) begin
				x_q <= -XW'(dx);
				y_q <= -XW'(dy);
				z_q <= (dy >= 0) ? PI_Q24 : -PI_Q24;
			end else begin
				x_q <= XW'(dx);
				y_q <= XW'(dy);
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q24(5'(i_q));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q24(5'(i_q));
			end
		end
	end

	assign zr = z_q + ZW'(1024);
	assign busy = busy_q;
	assign bearing = BW'(zr >>> 11);

endmodule

// ----- rtl/core/go_to_goal_pi_controller.sv -----
// ----------------------------------------------------------------------------
// go_to_goal_pi_controller
// Distance and bearing to a target, heading wrap, PI speed and P turn rate.
// ----------------------------------------------------------------------------
// Steps: an accepted input passes the squaring states S_SQ0 to S_SQ4, the bit-serial
// square root (S_SQS, S_ROOT), the error stage and S_M1 to S_M5 on one 33x17 multiplier.
// A new input is taken only in S_IDLE, so one item finishes before the next starts. A
// result still waiting for out_ready holds the block in its last step. The CORDIC runs
// beside the squaring and root; S_ROOT waits until both are done.
// Reset: registers return to their default values, the distance integral is zero.
module go_to_goal_pi_controller import gtg_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] heading,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic [15:0]        tick_seconds,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        linear_velocity,
	output logic signed [16:0] angular_velocity,
	output logic               arrived,
	output logic               integral_saturated,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQ0  = 4'd1;
	localparam logic [3:0] S_SQ1  = 4'd2;
	localparam logic [3:0] S_SQ2  = 4'd3;
	localparam logic [3:0] S_SQ3  = 4'd4;
	localparam logic [3:0] S_SQ4  = 4'd5;
	localparam logic [3:0] S_SQS  = 4'd6;
	localparam logic [3:0] S_ROOT = 4'd7;
	localparam logic [3:0] S_ERR  = 4'd8;
	localparam logic [3:0] S_M1   = 4'd9;
	localparam logic [3:0] S_M2   = 4'd10;
	localparam logic [3:0] S_M3   = 4'd11;
	localparam logic [3:0] S_M4   = 4'd12;
	localparam logic [3:0] S_M5   = 4'd13;

	// configuration
	logic [15:0] max_vel_q, max_turn_q, kp_dist_q, kp_head_q, ki_dist_q;
	logic [30:0] arr_rad_q;
	logic [14:0] turn_ang_q, deadband_q;
	logic        cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_vel_q <= 16'd4096;
			max_turn_q <= 16'd4096;
			kp_dist_q <= 16'd3277;
			kp_head_q <= 16'd4096;
			ki_dist_q <= 16'd819;
			arr_rad_q <= 31'd13107;
			turn_ang_q <= 15'd5147;
			deadband_q <= 15'd715;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_MAX_VEL:  max_vel_q <= pwdata[15:0];
				REG_MAX_TURN: max_turn_q <= pwdata[15:0];
				REG_KP_DIST:  kp_dist_q <= pwdata[15:0];
				REG_KP_HEAD:  kp_head_q <= pwdata[15:0];
				REG_KI_DIST:  ki_dist_q <= pwdata[15:0];
				REG_ARR_RAD:  arr_rad_q <= pwdata[30:0];
				REG_TURN_ANG: turn_ang_q <= pwdata[14:0];
				REG_DEADBAND: deadband_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_MAX_VEL:  prdata = {16'd0, max_vel_q};
			REG_MAX_TURN: prdata = {16'd0, max_turn_q};
			REG_KP_DIST:  prdata = {16'd0, kp_dist_q};
			REG_KP_HEAD:  prdata = {16'd0, kp_head_q};
			REG_KI_DIST:  prdata = {16'd0, ki_dist_q};
			REG_ARR_RAD:  prdata = {1'b0, arr_rad_q};
			REG_TURN_ANG: prdata = {17'd0, turn_ang_q};
			REG_DEADBAND: prdata = {17'd0, deadband_q};
			default:      prdata = '0;
		endcase
	end

	// datapath state
	logic [3:0]            state_q;
	logic signed [15:0]    hd_q;
	logic [15:0]           tick_q;
	logic [DW-1:0]         ax_q, ay_q;
	logic [65:0]           acc_q;
	logic [31:0]           errd_q;
	logic signed [EW-1:0]  erry_q;
	logic                  arr_q, sat_q;
	logic [48:0]           vacc_q;
	logic [31:0]           integral_q;
	logic                  out_valid_q;
	logic [15:0]           lin_q;
	logic signed [16:0]    ang_q;
	logic                  arrived_q, sat_out_q;

	logic                  accept;
	logic signed [DW-1:0]  dx_in, dy_in;
	unit_ctl_t             cr_ctl, sq_ctl;
	logic signed [BW-1:0]  bearing;
	logic [31:0]           root;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign dx_in = DW'(target_x) - DW'(pos_x);
	assign dy_in = DW'(target_y) - DW'(pos_y);
	assign cr_ctl.start = accept;
	assign sq_ctl.start = (state_q == S_SQS);

	gtg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cr_ctl.start),
		.dx      (dx_in),
		.dy      (dy_in),
		.busy    (cr_ctl.busy),
		.bearing (bearing)
	);

	gtg_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_ctl.start),
		.radicand (acc_q[63:0]),
		.busy     (sq_ctl.busy),
		.root     (root)
	);

	// shared multiplier operand select
	logic           mul_en;
	logic [MAW-1:0] mul_a;
	logic [MBW-1:0] mul_b;
	logic [MPW-1:0] prod;
	logic [EW-1:0]  erry_abs;

	assign erry_abs = erry_q[EW-1] ? EW'(-erry_q) : EW'(erry_q);

	always_comb begin
		mul_en = 1'b1;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ0: begin mul_a = ax_q; mul_b = {1'b0, ax_q[15:0]}; end
			S_SQ1: begin mul_a = ax_q; mul_b = ax_q[32:16]; end
			S_SQ2: begin mul_a = ay_q; mul_b = {1'b0, ay_q[15:0]}; end
			S_SQ3: begin mul_a = ay_q; mul_b = ay_q[32:16]; end
			S_M1:  begin mul_a = MAW'(errd_q); mul_b = MBW'(tick_q); end
			S_M2:  begin mul_a = MAW'(errd_q); mul_b = MBW'(kp_dist_q); end
			S_M3:  begin mul_a = MAW'(integral_q); mul_b = MBW'(ki_dist_q); end
			S_M4:  begin mul_a = MAW'(erry_abs); mul_b = MBW'(kp_head_q); end
			default: mul_en = 1'b0;
		endcase
	end

	gtg_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// error stage: wrap, arrival, turn-first
	logic signed [EW-1:0] e0, e1, e2, e2_abs;
	logic                 arr_now;
	logic [31:0]          dist_now;

	always_comb begin
		dist_now = (acc_q[65:64] != 2'b00) ? INTEGRAL_MAX : root;
		e0 = EW'(bearing) - EW'(hd_q);
		e1 = e0;
		if (e1 >= PI_Q13) begin
			e1 = e1 - TWO_PI_Q13;
		end
		if (e1 <= -PI_Q13) begin
			e1 = e1 + TWO_PI_Q13;
		end
		arr_now = (dist_now < {1'b0, arr_rad_q});
		e2 = arr_now ? '0 : e1;
		e2_abs = (e2 < 0) ? -e2 : e2;
	end

	// final stage
	logic [32:0] isum;
	logic [48:0] vsum;
	logic [32:0] v_raw;
	logic [34:0] wm;
	logic [22:0] wmag;
	logic [15:0] wlim;
	logic [15:0] v_cap;

	assign isum = {1'b0, integral_q} + {1'b0, prod[47:16]};
	assign vsum = vacc_q + 49'(prod[47:0]);
	assign v_raw = vacc_q[48:16];
	assign v_cap = (v_raw > {17'd0, max_vel_q}) ? max_vel_q : v_raw[15:0];

	always_comb begin
		wm = prod[34:0];
		wmag = erry_q[EW-1] ? 23'((wm + 35'd8191) >> 13) : 23'(wm >> 13);
		if ((erry_abs <= EW'(deadband_q)) || (errd_q >= TEN_M_Q16)) begin
			wmag = '0;
		end
		wlim = (wmag > {7'd0, max_turn_q}) ? max_turn_q : wmag[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			integral_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_M5) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_SQ0;
				S_SQ0:  state_q <= S_SQ1;
				S_SQ1:  state_q <= S_SQ2;
				S_SQ2:  state_q <= S_SQ3;
				S_SQ3:  state_q <= S_SQ4;
				S_SQ4:  state_q <= S_SQS;
				S_SQS:  state_q <= S_ROOT;
				S_ROOT: if (!sq_ctl.busy && !cr_ctl.busy) state_q <= S_ERR;
				S_ERR:  state_q <= S_M1;
				S_M1:   state_q <= S_M2;
				S_M2: begin
					state_q <= S_M3;
					integral_q <= (isum >= {1'b0, INTEGRAL_MAX}) ? INTEGRAL_MAX : isum[31:0];
				end
				S_M3:   state_q <= S_M4;
				S_M4:   state_q <= S_M5;
				S_M5: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					ax_q <= dx_in[DW-1] ? DW'(-dx_in) : DW'(dx_in);
					ay_q <= dy_in[DW-1] ? DW'(-dy_in) : DW'(dy_in);
					hd_q <= heading;
					tick_q <= tick_seconds;
				end
			end
			S_SQ1: acc_q <= 66'(prod);
			S_SQ2: acc_q <= acc_q + (66'(prod) << 16);
			S_SQ3: acc_q <= acc_q + 66'(prod);
			S_SQ4: acc_q <= acc_q + (66'(prod) << 16);
			S_ERR: begin
				arr_q <= arr_now;
				erry_q <= e2;
				errd_q <= (arr_now || (e2_abs > EW'(turn_ang_q))) ? '0 : dist_now;
			end
			S_M2: sat_q <= (isum >= {1'b0, INTEGRAL_MAX});
			S_M3: vacc_q <= 49'(prod[47:0]);
			S_M4: vacc_q <= vsum;
			S_M5: begin
				if (!out_valid_q || out_ready) begin
					lin_q <= v_cap;
					ang_q <= erry_q[EW-1] ? -17'(wlim) : 17'(wlim);
					arrived_q <= arr_q;
					sat_out_q <= sat_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign linear_velocity = lin_q;
	assign angular_velocity = ang_q;
	assign arrived = arrived_q;
	assign integral_saturated = sat_out_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted item did not start work");
	a_arrived_no_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && arrived) |-> angular_velocity == 17'sd0)
		else $error("turn rate nonzero on arrival");
	a_turn_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (angular_velocity <= $signed({1'b0, max_turn_q}))
			&& (angular_velocity >= -$signed({1'b0, max_turn_q})))
		else $error("turn rate beyond limit");
	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && integral_saturated && state_q == S_IDLE) |-> integral_q == INTEGRAL_MAX)
		else $error("saturation flag without full integral");

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Go-to-goal PI controller: directed and random control ticks with random
// handshake gaps and stalls, checked field by field against a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import gtg_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PI_Q13_I = 25736;

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [15:0] hd;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic [15:0] tick;
	} tick_item_t;

	typedef struct {
		logic [15:0] lin;
		logic signed [16:0] ang;
		logic arr;
		logic sat;
	} command_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] pos_x = '0, pos_y = '0, target_x = '0, target_y = '0;
	logic signed [15:0] heading = '0;
	logic [15:0] tick_seconds = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] linear_velocity;
	logic signed [16:0] angular_velocity;
	logic arrived, integral_saturated;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	go_to_goal_pi_controller dut (.*);

	always #6 clk = ~clk;

	// predictor state
	longint unsigned cfg_vmax, cfg_wmax, cfg_kpd, cfg_kph, cfg_kid, cfg_rad, cfg_tfa, cfg_db;
	longint unsigned integ;

	tick_item_t pending_ticks[$];
	command_t expected_cmds[$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0, gap_left = 0;
	int hold_off = 0;
	bit long_hold_req = 1'b0;
	bit feed_pause = 1'b0;

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint bearing(longint dx, longint dy);
		longint x, y, z, nx;
		longint at[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
			262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};
		x = dx; y = dy; z = 0;
		if (x < 0) begin
			z = (dy >= 0) ? 52707179 : -52707179;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			if (y > 0) begin
				nx = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z += at[i];
			end else begin
				nx = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z -= at[i];
			end
			x = nx;
		end
		return floor_shr(z + 1024, 11);
	endfunction

	function automatic command_t control_tick(tick_item_t t);
		command_t c;
		longint dx, dy, eyaw, w, ayaw;
		longint unsigned ax, ay, sq, dmag, a, sum, v;
		dx = longint'(t.tx) - longint'(t.px);
		dy = longint'(t.ty) - longint'(t.py);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		a = ax * ax;
		sq = a + ay * ay;
		if (sq < a) dmag = 64'hFFFF_FFFF;
		else begin
			dmag = isqrt(sq);
			if (dmag > 64'hFFFF_FFFF) dmag = 64'hFFFF_FFFF;
		end
		eyaw = bearing(dx, dy) - longint'(t.hd);
		if (eyaw >= PI_Q13_I) eyaw -= 2 * PI_Q13_I;
		if (eyaw <= -PI_Q13_I) eyaw += 2 * PI_Q13_I;
		c.arr = 1'b0;
		c.sat = 1'b0;
		if (dmag < cfg_rad) begin
			dmag = 0;
			eyaw = 0;
			c.arr = 1'b1;
		end
		if (eyaw > longint'(cfg_tfa) || eyaw < -longint'(cfg_tfa)) dmag = 0;
		sum = integ + ((dmag * t.tick) >> 16);
		if (sum >= 64'hFFFF_FFFF) begin
			sum = 64'hFFFF_FFFF;
			c.sat = 1'b1;
		end
		integ = sum;
		v = (cfg_kpd * dmag + cfg_kid * integ) >> 16;
		if (v > cfg_vmax) v = cfg_vmax;
		w = floor_shr(longint'(cfg_kph) * eyaw, 13);
		ayaw = eyaw < 0 ? -eyaw : eyaw;
		if (ayaw <= longint'(cfg_db)) w = 0;
		if (dmag >= 655360) w = 0;
		if (w > longint'(cfg_wmax)) w = cfg_wmax;
		if (w < -longint'(cfg_wmax)) w = -longint'(cfg_wmax);
		c.lin = v[15:0];
		c.ang = w[16:0];
		return c;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MAX_VEL: cfg_vmax = val[15:0];
			REG_MAX_TURN: cfg_wmax = val[15:0];
			REG_KP_DIST: cfg_kpd = val[15:0];
			REG_KP_HEAD: cfg_kph = val[15:0];
			REG_KI_DIST: cfg_kid = val[15:0];
			REG_ARR_RAD: cfg_rad = val[30:0];
			REG_TURN_ANG: cfg_tfa = val[14:0];
			default: cfg_db = val[14:0];
		endcase
	endtask

	task automatic wait_idle();
		while (pending_ticks.size() != 0 || in_valid || expected_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_pos();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'sd1 <<< $urandom_range(0, 30) ^ $urandom_range(0, 255);
			default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
		endcase
	endfunction

	task automatic push_tick(logic signed [31:0] px, py, tx, ty,
			logic signed [15:0] hd, logic [15:0] tk);
		tick_item_t t;
		t.px = px; t.py = py; t.tx = tx; t.ty = ty; t.hd = hd; t.tick = tk;
		pending_ticks = {pending_ticks, t};
	endtask

	task automatic random_ticks(int n, bit near_target);
		logic signed [31:0] px, py;
		for (int i = 0; i < n; i++) begin
			px = rand_pos();
			py = rand_pos();
			if (near_target)
				push_tick(px, py, px + $signed($urandom_range(0, 1 << 18)) - (1 << 17),
					py + $signed($urandom_range(0, 1 << 18)) - (1 << 17),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			else
				push_tick(px, py, rand_pos(), rand_pos(),
					16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
						: $signed($urandom_range(0, 2 * PI_Q13_I)) - PI_Q13_I),
					16'($urandom_range(0, 65535)));
		end
	endtask

	// sender: bursts and gaps
	always @(posedge clk) begin
		tick_item_t t;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				t = pending_ticks.pop_front();
				expected_cmds = {expected_cmds, control_tick(t)};
			end
			if (!in_valid || in_ready) begin
				if (pending_ticks.size() != 0 && !feed_pause && gap_left == 0) begin
					t = pending_ticks[0];
					in_valid <= 1'b1;
					pos_x <= t.px; pos_y <= t.py; heading <= t.hd;
					target_x <= t.tx; target_y <= t.ty; tick_seconds <= t.tick;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 8);
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 80);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
					if (gap_left > 0) gap_left--;
				end
			end
		end
	end

	// receiver: stall pattern plus one long hold-off
	always @(posedge clk) begin
		command_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_cmds.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result at cycle %0d", cycles);
				end else begin
					e = expected_cmds.pop_front();
					if (linear_velocity !== e.lin || angular_velocity !== e.ang
							|| arrived !== e.arr || integral_saturated !== e.sat) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp lin=%0d ang=%0d arr=%b sat=%b got %0d %0d %b %b",
								e.lin, e.ang, e.arr, e.sat, linear_velocity,
								angular_velocity, arrived, integral_saturated);
					end
				end
			end
			if (long_hold_req) begin
				long_hold_req <= 1'b0;
				hold_off <= 1500;
				out_ready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (cycles % 512 < 200) ? 1'b1 : ($urandom_range(0, 3) != 0);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] mx;
		cfg_vmax = 4096; cfg_wmax = 4096; cfg_kpd = 3277; cfg_kph = 4096;
		cfg_kid = 819; cfg_rad = 13107; cfg_tfa = 5147; cfg_db = 715;
		integ = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, coincident pose, huge distance, wrap, arrival
		push_tick(0, 0, 0, 0, 0, 16'hFFFF);
		push_tick(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			16'sh7FFF, 16'hFFFF);
		push_tick(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 16'sh8000, 16'hFFFF);
		push_tick(0, 0, 1 << 16, 0, 0, 16'h8000);
		push_tick(0, 0, -(1 << 16), 1, -16'sd25000, 16'h1000);
		push_tick(0, 0, -(1 << 16), -1, 16'sd25000, 16'h1000);
		push_tick(0, 0, 0, 1 << 17, 16'sd12868, 16'h0100);
		push_tick(0, 0, 0, -(1 << 17), 0, 16'h0100);
		push_tick(100, 200, 100 + 5000, 200, 0, 16'h0001);
		push_tick(0, 0, 20 << 16, 3 << 16, 16'sd300, 0);
		push_tick(0, 0, 3 << 16, 3 << 16, 16'sd6000, 16'hFFFF);
		push_tick(0, 0, 2 << 16, 0, 16'sd700, 16'h4000);
		push_tick(0, 0, 2 << 16, 0, -16'sd2000, 16'h4000);
		push_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0,
			16'hFFFF);
		random_ticks(8, 0);
		wait_idle();

		// phase: extreme registers, long receiver hold-off while sending
		write_reg(REG_MAX_VEL, 32'hFFFF);
		write_reg(REG_MAX_TURN, 32'hFFFF);
		write_reg(REG_KP_DIST, 32'hFFFF);
		write_reg(REG_KP_HEAD, 32'hFFFF);
		write_reg(REG_KI_DIST, 32'hFFFF);
		write_reg(REG_ARR_RAD, 32'h7FFF_FFFF);
		write_reg(REG_TURN_ANG, 32'h7FFF);
		write_reg(REG_DEADBAND, 32'h7FFF);
		long_hold_req = 1'b1;
		random_ticks(40, 0);
		wait_idle();

		write_reg(REG_ARR_RAD, 32'h0);
		write_reg(REG_DEADBAND, 32'h0);
		write_reg(REG_TURN_ANG, 32'h0);
		write_reg(REG_MAX_VEL, 32'h0);
		write_reg(REG_MAX_TURN, 32'h0);
		random_ticks(40, 0);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			for (int r = 0; r < 8; r++) begin
				mx = (r == 5) ? $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 20)
					: $urandom();
				write_reg(r[2:0], mx);
			end
			if (ph == 2) write_reg(REG_KI_DIST, 32'h0);
			random_ticks(40, 0);
			random_ticks(40, 1);
			// pause sender until drained, then resume
			feed_pause = 1'b1;
			while (expected_cmds.size() != 0 || in_valid) @(posedge clk);
			feed_pause = 1'b0;
			wait_idle();
		end

		wait_idle();
		if (errors == 0 && expected_cmds.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
